// File: design/dbag_pkg.sv
// ----------------------------------------------------------------------------
// dbag_pkg: shared types and constants for the DMA block address generator
// Holds the engine state record, the input and result records and the
// command and geometry constants used by the step logic and the top level.
// ----------------------------------------------------------------------------
package dbag_pkg;

  localparam int AddrW   = 32;
  localparam int LenW    = 30;
  localparam int XW      = 16;
  localparam int YW      = 14;
  localparam int StrideW = 16;
  localparam int WinW    = 2;
  localparam int CntW    = 32;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // last byte of the 4-byte source window
  localparam logic [WinW-1:0] WIN_LAST = 2'd3;

  typedef struct packed {
    logic [AddrW-1:0]   src_ptr;
    logic [AddrW-1:0]   dst_ptr;
    logic [WinW-1:0]    win_off;
    logic [XW-1:0]      col_cnt;
    logic [YW-1:0]      row_cnt;
    logic [LenW-1:0]    bytes_left;
    logic [XW-1:0]      row_width;
    logic [YW-1:0]      row_total;
    logic [StrideW-1:0] src_stride;
    logic [StrideW-1:0] dst_stride;
    logic               src_inc;
    logic               two_d;
    logic               active;
    logic [CntW-1:0]    blk_cnt;
  } state_t;

  typedef struct packed {
    logic               cmd;
    logic               src_increment;
    logic               two_d_mode;
    logic [AddrW-1:0]   source_address;
    logic [AddrW-1:0]   dest_address;
    logic [LenW-1:0]    length_word;
    logic [StrideW-1:0] src_stride;
    logic [StrideW-1:0] dst_stride;
  } item_t;

  typedef struct packed {
    logic             move_valid;
    logic [AddrW-1:0] rd_address;
    logic [AddrW-1:0] wr_address;
    logic             last_of_block;
    logic             busy_res;
    logic [CntW-1:0]  blocks_done;
  } result_t;

endpackage

// File: design/dbag_step.sv
// ----------------------------------------------------------------------------
// dbag_step: next-state and result logic for one beat
// Pure combinational: takes the engine state and one input beat and gives
// the state after the beat and the result it produces.
// ----------------------------------------------------------------------------
module dbag_step (
  input  dbag_pkg::state_t  st,
  input  dbag_pkg::item_t   item,
  output dbag_pkg::state_t  st_nxt,
  output dbag_pkg::result_t res
);
  import dbag_pkg::*;

  logic [XW-1:0]    load_x;
  logic [YW-1:0]    load_y;
  logic [AddrW-1:0] src_adv;
  logic [AddrW-1:0] src_row_base;
  logic [WinW-1:0]  win_adv;
  logic [XW-1:0]    col_adv;
  logic [YW-1:0]    row_adv;
  logic [LenW-1:0]  bytes_dec;
  logic             done;

  assign load_x = item.length_word[XW-1:0];
  assign load_y = item.length_word[LenW-1:XW];

  // source after one byte: fixed source wraps back to window base after 4
  assign src_adv = (!st.src_inc && st.win_off == WIN_LAST) ?
                   st.src_ptr - AddrW'(WIN_LAST) : st.src_ptr + AddrW'(1);
  assign win_adv = st.src_inc ? st.win_off : st.win_off + WinW'(1);
  // window base (or next byte when incrementing) for the start of a new row
  assign src_row_base = st.src_inc ? st.src_ptr + AddrW'(1)
                                   : st.src_ptr - AddrW'(st.win_off);
  assign col_adv   = st.col_cnt + XW'(1);
  assign row_adv   = st.row_cnt + YW'(1);
  assign bytes_dec = st.bytes_left - LenW'(1);

  always_comb begin
    st_nxt = st;
    done   = 1'b0;
    res    = '0;
    if (item.cmd == CMD_LOAD) begin
      st_nxt.src_ptr    = item.source_address;
      st_nxt.dst_ptr    = item.dest_address;
      st_nxt.win_off    = '0;
      st_nxt.col_cnt    = '0;
      st_nxt.row_cnt    = '0;
      st_nxt.bytes_left = item.length_word;
      st_nxt.row_width  = load_x;
      st_nxt.row_total  = load_y;
      st_nxt.src_stride = item.src_stride;
      st_nxt.dst_stride = item.dst_stride;
      st_nxt.src_inc    = item.src_increment;
      st_nxt.two_d      = item.two_d_mode;
      st_nxt.active     = item.two_d_mode ? (load_x != '0 && load_y != '0)
                                          : (item.length_word != '0);
      done              = !st_nxt.active;
    end else if (st.active) begin
      res.move_valid = 1'b1;
      res.rd_address = st.src_ptr;
      res.wr_address = st.dst_ptr;
      st_nxt.src_ptr = src_adv;
      st_nxt.dst_ptr = st.dst_ptr + AddrW'(1);
      st_nxt.win_off = win_adv;
      if (st.two_d) begin
        st_nxt.col_cnt = col_adv;
        if (col_adv == st.row_width) begin
          st_nxt.src_ptr = src_row_base + AddrW'(st.src_stride);
          st_nxt.dst_ptr = st.dst_ptr + AddrW'(1) + AddrW'(st.dst_stride);
          st_nxt.win_off = '0;
          st_nxt.col_cnt = '0;
          st_nxt.row_cnt = row_adv;
          if (row_adv == st.row_total) begin
            st_nxt.active = 1'b0;
            done          = 1'b1;
          end
        end
      end else begin
        st_nxt.bytes_left = bytes_dec;
        if (bytes_dec == '0) begin
          st_nxt.active = 1'b0;
          done          = 1'b1;
        end
      end
    end
    if (done) begin
      st_nxt.blk_cnt = st.blk_cnt + CntW'(1);
    end
    res.last_of_block = done;
    res.busy_res      = st_nxt.active;
    res.blocks_done   = st_nxt.blk_cnt;
  end

endmodule

// File: design/dma_block_address_generator_top.sv
// ----------------------------------------------------------------------------
// dma_block_address_generator_top: DMA control-block address generator
// A load beat (cmd = 0) latches a control block; each step beat (cmd = 1)
// issues one source/destination byte address pair until the block is done.
//
// Input channel: in_valid / in_stall plus one port per field. A beat is
// taken on a rising edge with in_valid high and in_stall low.
// Result channel: out_valid / out_stall plus one port per field. Every input
// beat yields exactly one result beat, in order.
// Latency: the result is on the output register the cycle after the input
// beat is taken. Throughput: one beat per clock unless stalled; the engine
// state is updated as the beat is taken, so back-to-back steps need no bubble.
// Stall: while a result waits with out_stall high, in_stall is raised and
// the engine state holds; the pending result stays unchanged on the port.
// The next input beat is taken in the same cycle the held result drains.
// Reset (rst_n low, synchronous): engine idle, all pointers, counters and the
// completed-block count cleared, output register empty.
// ----------------------------------------------------------------------------
module dma_block_address_generator_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_cmd,
  input  logic                              in_src_increment,
  input  logic                              in_two_d_mode,
  input  logic [dbag_pkg::AddrW-1:0]        in_source_address,
  input  logic [dbag_pkg::AddrW-1:0]        in_dest_address,
  input  logic [dbag_pkg::LenW-1:0]         in_length_word,
  input  logic [dbag_pkg::StrideW-1:0]      in_src_stride,
  input  logic [dbag_pkg::StrideW-1:0]      in_dst_stride,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_move_valid,
  output logic [dbag_pkg::AddrW-1:0]        out_rd_address,
  output logic [dbag_pkg::AddrW-1:0]        out_wr_address,
  output logic                              out_last_of_block,
  output logic                              out_busy_res,
  output logic [dbag_pkg::CntW-1:0]         out_blocks_done
);
  import dbag_pkg::*;

  state_t  state_r;
  state_t  state_nxt;
  item_t   item;
  result_t res_nxt;
  result_t res_r;
  logic    out_valid_r;
  logic    in_take;

  assign in_stall = out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  assign item.cmd            = in_cmd;
  assign item.src_increment  = in_src_increment;
  assign item.two_d_mode     = in_two_d_mode;
  assign item.source_address = in_source_address;
  assign item.dest_address   = in_dest_address;
  assign item.length_word    = in_length_word;
  assign item.src_stride     = in_src_stride;
  assign item.dst_stride     = in_dst_stride;

  dbag_step u_step (
    .st     (state_r),
    .item   (item),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_take) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_move_valid    = res_r.move_valid;
  assign out_rd_address    = res_r.rd_address;
  assign out_wr_address    = res_r.wr_address;
  assign out_last_of_block = res_r.last_of_block;
  assign out_busy_res      = res_r.busy_res;
  assign out_blocks_done   = res_r.blocks_done;

endmodule

// File: design/dbag_checker.sv
// ----------------------------------------------------------------------------
// dbag_checker: port-level checks for the DMA block address generator
// Watches the result channel of the top level; attached by bind below.
// ----------------------------------------------------------------------------
module dbag_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_move_valid,
  input logic [dbag_pkg::AddrW-1:0]   out_rd_address,
  input logic [dbag_pkg::AddrW-1:0]   out_wr_address,
  input logic                         out_last_of_block,
  input logic                         out_busy_res,
  input logic [dbag_pkg::CntW-1:0]    out_blocks_done
);
  import dbag_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rd_address) &&
      $stable(out_wr_address) && $stable(out_blocks_done))
    else $error("stalled result beat changed");

  // loads and idle steps carry zero addresses
  a_no_move_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_move_valid |-> out_rd_address == '0 && out_wr_address == '0)
    else $error("non-move result carries an address");

  // a completing block leaves the engine idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_block |-> !out_busy_res)
    else $error("busy after last beat of block");

  // a move that does not finish the block keeps the engine busy
  a_move_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_move_valid && !out_last_of_block |-> out_busy_res)
    else $error("engine went idle without completing block");

endmodule

bind dma_block_address_generator_top dbag_checker u_dbag_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_move_valid    (out_move_valid),
  .out_rd_address    (out_rd_address),
  .out_wr_address    (out_wr_address),
  .out_last_of_block (out_last_of_block),
  .out_busy_res      (out_busy_res),
  .out_blocks_done   (out_blocks_done)
);
